// File: hw/rtl/svf_pkg.sv
// Shared types, constants and rounding helper for the state variable filter.
package svf_pkg;

  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 32;
  localparam int unsigned ProdW = 68;
  localparam int unsigned DivW  = 40;
  localparam int unsigned QuotW = 31;
  localparam int unsigned CfgDW = 19;

  typedef enum logic [2:0] {
    CFG_CUTOFF = 3'd0,
    CFG_DAMP   = 3'd1,
    CFG_DRIVE  = 3'd2,
    CFG_OGAIN  = 3'd3,
    CFG_STYLE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_LP = 2'd0,
    MODE_HP = 2'd1,
    MODE_BP = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    RND_0,
    RND_5,
    RND_16,
    RND_27,
    RND_30
  } rnd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DRV,
    ST_DX,
    ST_GG,
    ST_GK,
    ST_DSUM,
    ST_DST,
    ST_DIV,
    ST_C1,
    ST_C1W,
    ST_C2,
    ST_C2W,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_UPD,
    ST_MIX,
    ST_OUT,
    ST_OUTW
  } state_e;

  // round to nearest, ties away from zero
  function automatic logic signed [ProdW-1:0] rnd_shift(input logic signed [ProdW-1:0] p,
                                                        input rnd_e sh);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] r;
    mag = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    unique case (sh)
      RND_0:   r = mag;
      RND_5:   r = (mag + (ProdW'(1) << 4)) >> 5;
      RND_16:  r = (mag + (ProdW'(1) << 15)) >> 16;
      RND_27:  r = (mag + (ProdW'(1) << 26)) >> 27;
      RND_30:  r = (mag + (ProdW'(1) << 29)) >> 30;
      default: r = mag;
    endcase
    return p[ProdW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// File: hw/rtl/svf_mul.sv
// Shared signed multiplier with registered product.
module svf_mul (
  input  logic                               clk_i,
  input  logic signed [svf_pkg::MulAW-1:0]   a_i,
  input  logic signed [svf_pkg::MulBW-1:0]   b_i,
  output logic signed [svf_pkg::ProdW-1:0]   prod_o
);

  logic signed [svf_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= svf_pkg::ProdW'(a_i) * svf_pkg::ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: hw/rtl/svf_div.sv
// Restoring divider, one quotient bit per cycle, for 2^62 + d/2 over d.
module svf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [svf_pkg::DivW-1:0]      divisor_i,
  output logic                          done_o,
  output logic [svf_pkg::QuotW-1:0]     quot_o
);

  localparam int unsigned RemW = svf_pkg::DivW + svf_pkg::QuotW;

  logic [RemW-1:0]            rem_q, rem_d, dsh_q, dsh_d;
  logic [svf_pkg::QuotW-1:0]  quot_q, quot_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [RemW:0]              diff;

  always_comb begin
    diff   = {1'b0, rem_q} - {1'b0, dsh_q};
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = (RemW'(1) << 62) + RemW'(divisor_i >> 1);
      dsh_d  = RemW'(divisor_i) << (svf_pkg::QuotW - 1);
      quot_d = '0;
      cnt_d  = 5'(svf_pkg::QuotW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[RemW]) begin
        rem_d  = diff[RemW-1:0];
        quot_d = {quot_q[svf_pkg::QuotW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[svf_pkg::QuotW-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: hw/rtl/state_variable_filter_12_24db_unit.sv
// Top level: sequencer and datapath of the trapezoidal state variable filter.
// In both the 12 dB and the 24 dB styles, the next beat can be taken in the
// cycle that the result of the last beat is first shown on the output. Each
// filter stage recomputes its coefficients: the 31-step divider forms
// 1/(g*g + g*k + 1), and the other products go through the one shared
// multiplier. A clear beat zeroes the filter state and returns 0. A stalled
// output holds the sequencer in ST_OUT until the result register can be
// refilled. in_stall_o is high while a beat is in work. A finished result waits
// in the output register while the next beat is taken; configuration writes are
// always ready and must only be made while the block is idle.
module state_variable_filter_12_24db_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic signed [15:0]          sample_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          sample_out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [svf_pkg::CfgDW-1:0]   cfg_data_i
);

  localparam logic signed [39:0] ClipHi = 40'sd67108864;
  localparam logic signed [39:0] ClipLo = -40'sd67108864;

  svf_pkg::state_e state_q, state_d;
  svf_pkg::mode_e  mode_q, mode_d;
  logic            pre_q, pre_d;

  logic [18:0] cutoff_q;
  logic [17:0] damp_q;
  logic [16:0] drive_q, ogain_q;
  logic [2:0]  style_q;

  logic signed [31:0] band_q, band_d, low_q, low_d, pband_q, pband_d, plow_q, plow_d;
  logic signed [15:0] s_q, s_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic signed [28:0] in_q, in_d;
  logic [39:0]        d_q, d_d;
  logic [30:0]        c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic signed [31:0] b_q, b_d, l_q, l_d;
  logic signed [39:0] acc_q, acc_d;
  logic signed [35:0] v1_q, v1_d, v2_q, v2_d;
  logic signed [27:0] y_q, y_d;

  logic signed [svf_pkg::MulAW-1:0] mul_a;
  logic signed [svf_pkg::MulBW-1:0] mul_b;
  logic signed [svf_pkg::ProdW-1:0] prod, rnd;
  svf_pkg::rnd_e                    sh;
  logic                             div_start, div_done;
  logic [svf_pkg::QuotW-1:0]        quot;

  logic [17:0]        kc;
  logic signed [32:0] v3;
  logic signed [37:0] nb, nl;
  logic signed [39:0] mixv;

  svf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  svf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign kc  = pre_q ? 18'd65536 : damp_q;
  assign v3  = $signed({{4{in_q[28]}}, in_q}) - $signed({l_q[31], l_q});
  assign nb  = $signed({v1_q[35], v1_q, 1'b0}) - 38'(b_q);
  assign nl  = $signed({v2_q[35], v2_q, 1'b0}) - 38'(l_q);
  assign rnd = svf_pkg::rnd_shift(prod, sh);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pre_d       = pre_q;
    band_d      = band_q;
    low_d       = low_q;
    pband_d     = pband_q;
    plow_d      = plow_q;
    s_d         = s_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_d        = in_q;
    d_d         = d_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    b_d         = b_q;
    l_d         = l_q;
    acc_d       = acc_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    y_d         = y_q;
    mul_a       = '0;
    mul_b       = '0;
    sh          = svf_pkg::RND_0;
    div_start   = 1'b0;
    mixv        = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      svf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            band_d  = '0;
            low_d   = '0;
            pband_d = '0;
            plow_d  = '0;
            y_d     = '0;
            state_d = svf_pkg::ST_OUT;
          end else begin
            s_d = sample_in_i;
            unique case (style_q)
              3'd0: begin mode_d = svf_pkg::MODE_LP; pre_d = 1'b0; end
              3'd1: begin mode_d = svf_pkg::MODE_HP; pre_d = 1'b0; end
              3'd2: begin mode_d = svf_pkg::MODE_BP; pre_d = 1'b0; end
              3'd3: begin mode_d = svf_pkg::MODE_LP; pre_d = 1'b1; end
              3'd4: begin mode_d = svf_pkg::MODE_HP; pre_d = 1'b1; end
              3'd5: begin mode_d = svf_pkg::MODE_BP; pre_d = 1'b1; end
              default: begin mode_d = svf_pkg::MODE_LP; pre_d = 1'b0; end
            endcase
            state_d = svf_pkg::ST_DRV;
          end
        end
      end
      svf_pkg::ST_DRV: begin
        mul_a   = 36'(s_q);
        mul_b   = $signed({15'd0, drive_q});
        state_d = svf_pkg::ST_DX;
      end
      svf_pkg::ST_DX: begin
        sh      = svf_pkg::RND_5;
        in_d    = rnd[28:0];
        state_d = svf_pkg::ST_GG;
      end
      svf_pkg::ST_GG: begin
        mul_a   = $signed({17'd0, cutoff_q});
        mul_b   = $signed({13'd0, cutoff_q});
        state_d = svf_pkg::ST_GK;
      end
      svf_pkg::ST_GK: begin
        mul_a   = $signed({18'd0, kc});
        mul_b   = $signed({13'd0, cutoff_q});
        d_d     = prod[39:0];
        state_d = svf_pkg::ST_DSUM;
      end
      svf_pkg::ST_DSUM: begin
        d_d     = d_q + prod[39:0] + (40'd1 << 32);
        state_d = svf_pkg::ST_DST;
      end
      svf_pkg::ST_DST: begin
        div_start = 1'b1;
        state_d   = svf_pkg::ST_DIV;
      end
      svf_pkg::ST_DIV: begin
        if (div_done) begin
          c0_d    = quot;
          state_d = svf_pkg::ST_C1;
        end
      end
      svf_pkg::ST_C1: begin
        mul_a   = $signed({5'd0, c0_q});
        mul_b   = $signed({13'd0, cutoff_q});
        state_d = svf_pkg::ST_C1W;
      end
      svf_pkg::ST_C1W: begin
        sh      = svf_pkg::RND_16;
        c1_d    = rnd[30:0];
        state_d = svf_pkg::ST_C2;
      end
      svf_pkg::ST_C2: begin
        mul_a   = $signed({5'd0, c1_q});
        mul_b   = $signed({13'd0, cutoff_q});
        state_d = svf_pkg::ST_C2W;
      end
      svf_pkg::ST_C2W: begin
        sh      = svf_pkg::RND_16;
        c2_d    = rnd[30:0];
        b_d     = pre_q ? pband_q : band_q;
        l_d     = pre_q ? plow_q : low_q;
        state_d = svf_pkg::ST_M1;
      end
      svf_pkg::ST_M1: begin
        mul_a   = 36'(b_q);
        mul_b   = $signed({1'b0, c0_q});
        state_d = svf_pkg::ST_M2;
      end
      svf_pkg::ST_M2: begin
        mul_a   = 36'(v3);
        mul_b   = $signed({1'b0, c1_q});
        sh      = svf_pkg::RND_30;
        acc_d   = $signed(rnd[39:0]);
        state_d = svf_pkg::ST_M3;
      end
      svf_pkg::ST_M3: begin
        mul_a   = 36'(b_q);
        mul_b   = $signed({1'b0, c1_q});
        sh      = svf_pkg::RND_30;
        v1_d    = 36'(acc_q + $signed(rnd[39:0]));
        state_d = svf_pkg::ST_M4;
      end
      svf_pkg::ST_M4: begin
        mul_a   = 36'(v3);
        mul_b   = $signed({1'b0, c2_q});
        sh      = svf_pkg::RND_30;
        acc_d   = 40'(l_q) + $signed(rnd[39:0]);
        state_d = svf_pkg::ST_M5;
      end
      svf_pkg::ST_M5: begin
        sh      = svf_pkg::RND_30;
        v2_d    = 36'(acc_q + $signed(rnd[39:0]));
        state_d = svf_pkg::ST_UPD;
      end
      svf_pkg::ST_UPD: begin
        if (pre_q) begin
          pband_d = sat32(nb);
          plow_d  = sat32(nl);
        end else begin
          band_d = sat32(nb);
          low_d  = sat32(nl);
        end
        mul_a   = v1_q;
        mul_b   = $signed({14'd0, kc});
        state_d = svf_pkg::ST_MIX;
      end
      svf_pkg::ST_MIX: begin
        sh = svf_pkg::RND_16;
        unique case (mode_q)
          svf_pkg::MODE_HP: mixv = 40'(in_q) - $signed(rnd[39:0]) - 40'(v2_q);
          svf_pkg::MODE_BP: mixv = 40'(v1_q);
          default:          mixv = 40'(v2_q);
        endcase
        if (mixv > ClipHi) begin
          mixv = ClipHi;
        end else if (mixv < ClipLo) begin
          mixv = ClipLo;
        end
        if (pre_q) begin
          in_d    = mixv[28:0];
          pre_d   = 1'b0;
          state_d = svf_pkg::ST_GG;
        end else begin
          y_d     = mixv[27:0];
          state_d = svf_pkg::ST_OUT;
        end
      end
      svf_pkg::ST_OUT: begin
        mul_a = 36'(y_q);
        mul_b = $signed({15'd0, ogain_q});
        if (!out_valid_q || !out_stall_i) begin
          state_d = svf_pkg::ST_OUTW;
        end
      end
      svf_pkg::ST_OUTW: begin
        sh = svf_pkg::RND_27;
        if (rnd > 68'sd32767) begin
          out_d = 16'sh7FFF;
        end else if (rnd < -68'sd32768) begin
          out_d = 16'sh8000;
        end else begin
          out_d = rnd[15:0];
        end
        out_valid_d = 1'b1;
        state_d     = svf_pkg::ST_IDLE;
      end
      default: state_d = svf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svf_pkg::ST_IDLE;
      mode_q      <= svf_pkg::MODE_LP;
      pre_q       <= 1'b0;
      out_valid_q <= 1'b0;
      band_q      <= '0;
      low_q       <= '0;
      pband_q     <= '0;
      plow_q      <= '0;
      cutoff_q    <= 19'd4293;
      damp_q      <= 18'd131072;
      drive_q     <= 17'd65536;
      ogain_q     <= 17'd65536;
      style_q     <= 3'd0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pre_q       <= pre_d;
      out_valid_q <= out_valid_d;
      band_q      <= band_d;
      low_q       <= low_d;
      pband_q     <= pband_d;
      plow_q      <= plow_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          svf_pkg::CFG_CUTOFF: cutoff_q <= cfg_data_i;
          svf_pkg::CFG_DAMP:   damp_q   <= cfg_data_i[17:0];
          svf_pkg::CFG_DRIVE:  drive_q  <= cfg_data_i[16:0];
          svf_pkg::CFG_OGAIN:  ogain_q  <= cfg_data_i[16:0];
          svf_pkg::CFG_STYLE:  style_q  <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    out_q <= out_d;
    in_q  <= in_d;
    d_q   <= d_d;
    c0_q  <= c0_d;
    c1_q  <= c1_d;
    c2_q  <= c2_d;
    b_q   <= b_d;
    l_q   <= l_d;
    acc_q <= acc_d;
    v1_q  <= v1_d;
    v2_q  <= v2_d;
    y_q   <= y_d;
  end

  assign in_stall_o   = (state_q != svf_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign cfg_ready_o  = 1'b1;

endmodule
